@@ rtl/atm_pkg.sv @@
// atm_pkg: shared types, constants and text tables of the AT command modem front end
// used by atm_front, atm_queue, atm_back and the top level
// depends on nothing
package atm_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam int LEN_W     = 7;
  localparam int ADDR_W    = 9;
  localparam int TEXT_W    = 192;
  localparam int WALK_MAX  = 22;
  localparam int CMD_COUNT = 6;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_LINK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_TEXT       = 2'd0,
    KIND_CONNECT    = 2'd1,
    KIND_DISCONNECT = 2'd2,
    KIND_RESTART    = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    PH_BEGIN        = 7'b0000001,
    PH_DATA         = 7'b0000010,
    PH_PAUSE_BEFORE = 7'b0000100,
    PH_PLUS1        = 7'b0001000,
    PH_PLUS2        = 7'b0010000,
    PH_PLUS3        = 7'b0100000,
    PH_PAUSE_AFTER  = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    MSG_AVAILABLE = 4'd0,
    MSG_NO_CONN   = 4'd1,
    MSG_HUNG_UP   = 4'd2,
    MSG_VERBOSE   = 4'd3,
    MSG_NUMERIC   = 4'd4,
    MSG_RESTART   = 4'd5,
    MSG_UNKNOWN   = 4'd6,
    MSG_CMD_MODE  = 4'd7,
    MSG_CONNECT   = 4'd8
  } msg_t;

  typedef enum logic [2:0] {
    CMD_AT      = 3'd0,
    CMD_ATDP    = 3'd1,
    CMD_ATH0    = 3'd2,
    CMD_ATV0    = 3'd3,
    CMD_ATV1    = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_t;

  typedef struct packed {
    logic              run;
    logic [1:0]        channel;
    msg_t              msg;
    logic [LEN_W-1:0]  length;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  function automatic logic [7:0] byte_at(input logic [TEXT_W-1:0] text,
                                         input logic [4:0] len,
                                         input logic [4:0] k);
    logic [TEXT_W-1:0] t;
    t = text >> {len - k - 5'd1, 3'b000};
    return t[7:0];
  endfunction

  function automatic logic [TEXT_W-1:0] msg_text(input msg_t m);
    logic [TEXT_W-1:0] t;
    case (m)
      MSG_AVAILABLE: t = "0 OK, modem available";
      MSG_NO_CONN:   t = "4 ERROR, no connection";
      MSG_HUNG_UP:   t = "0 OK, disconnected";
      MSG_VERBOSE:   t = "0 OK, verbose answers";
      MSG_NUMERIC:   t = "0 OK, numeric answers";
      MSG_RESTART:   t = "0 OK, going to restart";
      MSG_UNKNOWN:   t = "4 ERROR, unknown command";
      MSG_CMD_MODE:  t = "0 OK, command mode";
      MSG_CONNECT:   t = "1 CONNECT";
      default:       t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] msg_len(input msg_t m);
    logic [4:0] n;
    case (m)
      MSG_AVAILABLE: n = 5'd21;
      MSG_NO_CONN:   n = 5'd22;
      MSG_HUNG_UP:   n = 5'd18;
      MSG_VERBOSE:   n = 5'd21;
      MSG_NUMERIC:   n = 5'd21;
      MSG_RESTART:   n = 5'd22;
      MSG_UNKNOWN:   n = 5'd24;
      MSG_CMD_MODE:  n = 5'd18;
      MSG_CONNECT:   n = 5'd9;
      default:       n = 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [TEXT_W-1:0] cmd_text(input cmd_t c);
    logic [TEXT_W-1:0] t;
    case (c)
      CMD_AT:      t = "AT";
      CMD_ATDP:    t = "ATDP";
      CMD_ATH0:    t = "ATH0";
      CMD_ATV0:    t = "ATV0";
      CMD_ATV1:    t = "ATV1";
      CMD_RESTART: t = "AT-RESTART";
      default:     t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] cmd_len(input cmd_t c);
    logic [4:0] n;
    case (c)
      CMD_AT:      n = 5'd2;
      CMD_RESTART: n = 5'd10;
      default:     n = 5'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

endpackage

@@ rtl/atm_queue.sv @@
// atm_queue: two-entry job queue between front and back
// depends on atm_pkg
module atm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  atm_pkg::job_t   push_job,
  output logic            full,
  input  logic            pop,
  output atm_pkg::job_t   head,
  output logic            empty
);

  atm_pkg::job_t entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

@@ rtl/atm_front.sv @@
// atm_front: accepts items, keeps per-channel mode, escape and line state, config registers
// writes the line store and queues jobs; depends on atm_pkg
module atm_front #(
  parameter int CHANNELS   = 4,
  parameter int LINE_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [1:0]          channel,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                job_push,
  output atm_pkg::job_t       job,
  input  logic                job_full,
  output atm_pkg::store_wr_t  store_wr,
  input  logic                run_done
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW = $clog2(LINE_BYTES + 1);

  logic [3:0]          mask;
  logic [7:0]          guard;
  logic                run_pending;

  logic                data_mode  [CHANNELS];
  logic                collecting [CHANNELS];
  logic [LW-1:0]       len        [CHANNELS];
  atm_pkg::phase_t     phase      [CHANNELS];
  logic [7:0]          silence    [CHANNELS];

  logic                accept;
  logic                en;
  logic [CW-1:0]       ci;
  logic                dm_next;
  logic                col_next;
  logic [LW-1:0]       len_next;
  atm_pkg::phase_t     phase_next;
  atm_pkg::phase_t     ph_tick;
  logic [7:0]          sil_next;
  logic [LW-1:0]       lenw;

  assign cfg_ready = 1'b1;
  assign full      = job_full || run_pending;
  assign accept    = push && !full;
  assign ci        = CW'(channel);
  assign en        = accept && (int'(channel) < CHANNELS) && mask[channel];

  always_comb begin
    dm_next     = data_mode[ci];
    col_next    = collecting[ci];
    len_next    = len[ci];
    phase_next  = phase[ci];
    sil_next    = silence[ci];
    ph_tick     = phase[ci];
    lenw        = '0;
    job_push    = 1'b0;
    job.run     = 1'b0;
    job.channel = channel;
    job.msg     = atm_pkg::MSG_UNKNOWN;
    job.length  = '0;
    store_wr.en   = 1'b0;
    store_wr.addr = '0;
    store_wr.data = rx_byte;
    case (operation)
      atm_pkg::OP_BYTE: begin
        if (data_mode[ci]) begin
          sil_next = 8'd0;
          if (phase[ci] == atm_pkg::PH_PAUSE_BEFORE && rx_byte == atm_pkg::CHAR_PLUS) begin
            phase_next = atm_pkg::PH_PLUS1;
          end else if (phase[ci] == atm_pkg::PH_PLUS1 && rx_byte == atm_pkg::CHAR_PLUS) begin
            phase_next = atm_pkg::PH_PLUS2;
          end else if (phase[ci] == atm_pkg::PH_PLUS2 && rx_byte == atm_pkg::CHAR_PLUS) begin
            phase_next = atm_pkg::PH_PLUS3;
          end else begin
            phase_next = atm_pkg::PH_DATA;
          end
        end else begin
          lenw = collecting[ci] ? len[ci] : '0;
          if (int'(lenw) >= LINE_BYTES) begin
            lenw = '0;
          end
          store_wr.en   = en;
          store_wr.addr = atm_pkg::ADDR_W'(int'(ci) * LINE_BYTES + int'(lenw));
          len_next      = lenw + LW'(1);
          if (rx_byte == atm_pkg::CHAR_CR || rx_byte == atm_pkg::CHAR_LF) begin
            col_next   = 1'b0;
            job_push   = en;
            job.run    = 1'b1;
            job.length = atm_pkg::LEN_W'(len_next);
          end else begin
            col_next = 1'b1;
          end
        end
      end
      atm_pkg::OP_TICK: begin
        if (silence[ci] >= guard) begin
          if (phase[ci] == atm_pkg::PH_DATA) begin
            ph_tick = atm_pkg::PH_PAUSE_BEFORE;
          end else if (phase[ci] == atm_pkg::PH_PLUS3) begin
            ph_tick = atm_pkg::PH_PAUSE_AFTER;
          end
        end else begin
          sil_next = silence[ci] + 8'd1;
        end
        phase_next = ph_tick;
        if (data_mode[ci] && ph_tick == atm_pkg::PH_PAUSE_AFTER) begin
          dm_next    = 1'b0;
          phase_next = atm_pkg::PH_BEGIN;
          job_push   = en;
          job.msg    = atm_pkg::MSG_CMD_MODE;
        end
      end
      atm_pkg::OP_LINK: begin
        if (!data_mode[ci]) begin
          dm_next  = 1'b1;
          job_push = en;
          job.msg  = atm_pkg::MSG_CONNECT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask        <= 4'd0;
      guard       <= 8'd10;
      run_pending <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        data_mode[c]  <= 1'b0;
        collecting[c] <= 1'b0;
        len[c]        <= '0;
        phase[c]      <= atm_pkg::PH_BEGIN;
        silence[c]    <= 8'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'b0) begin
          mask <= cfg_data[3:0];
        end else begin
          guard <= cfg_data;
        end
      end
      if (job_push && job.run) begin
        run_pending <= 1'b1;
      end else if (run_done) begin
        run_pending <= 1'b0;
      end
      if (en) begin
        data_mode[ci]  <= dm_next;
        collecting[ci] <= col_next;
        len[ci]        <= len_next;
        phase[ci]      <= phase_next;
        silence[ci]    <= sil_next;
      end
    end
  end

endmodule

@@ rtl/atm_back.sv @@
// atm_back: line store, command match and dial walk, answer text sequencer, result register
// depends on atm_pkg
module atm_back #(
  parameter int CHANNELS   = 4,
  parameter int LINE_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  atm_pkg::store_wr_t  store_wr,
  input  logic                q_empty,
  input  atm_pkg::job_t       q_head,
  output logic                q_pop,
  output logic                run_done,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind,
  output logic [1:0]          out_channel,
  output logic [7:0]          tx_byte,
  output logic [31:0]         ip_address,
  output logic [15:0]         port,
  output logic                last
);

  localparam int DEPTH = CHANNELS * LINE_BYTES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WALK   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_PRE    = 6'b001000,
    S_TEXT   = 6'b010000,
    S_POST   = 6'b100000
  } state_t;

  logic [7:0] store [DEPTH];
  logic [7:0] rdata;
  logic [AW-1:0] raddr;

  state_t                     state;
  logic [1:0]                 ch;
  logic [atm_pkg::LEN_W-1:0]  llen;
  atm_pkg::msg_t              msg;
  atm_pkg::kind_e             post_kind;
  logic [4:0]                 issue_pos;
  logic [4:0]                 walk_n;
  logic                       rd_v;
  logic [4:0]                 rd_pos;
  logic [atm_pkg::CMD_COUNT-1:0] match;
  logic                       dig_ok;
  logic [9:0]                 oct;
  logic [16:0]                prt;
  logic [31:0]                ip;
  logic                       verbose;
  logic [4:0]                 tidx;
  logic                       ovalid;

  logic [atm_pkg::CMD_COUNT-1:0] match_next;
  logic                       dig_ok_next;
  logic [9:0]                 oct_next;
  logic [16:0]                prt_next;
  logic [31:0]                ip_next;
  logic [7:0]                 up;
  logic [3:0]                 digit;
  logic                       slot_free;
  logic [4:0]                 tcount;
  logic [7:0]                 tchar;
  logic [4:0]                 mlen;

  assign raddr     = AW'(int'(ch) * LINE_BYTES + int'(issue_pos));
  assign slot_free = !ovalid || pop;
  assign empty     = !ovalid;
  assign run_done  = state == S_DECIDE;
  assign q_pop     = state == S_IDLE && !q_empty;
  assign mlen      = atm_pkg::msg_len(msg);
  assign tcount    = verbose ? mlen + 5'd2 : 5'd3;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[AW'(store_wr.addr)] <= store_wr.data;
    end
    rdata <= store[raddr];
  end

  always_comb begin
    match_next  = match;
    dig_ok_next = dig_ok;
    oct_next    = oct;
    prt_next    = prt;
    ip_next     = ip;
    up          = atm_pkg::upcase(rdata);
    digit       = 4'(rdata - atm_pkg::CHAR_ZERO);
    for (int k = 0; k < atm_pkg::CMD_COUNT; k++) begin
      if (rd_pos < atm_pkg::cmd_len(atm_pkg::cmd_t'(k)) &&
          up != atm_pkg::byte_at(atm_pkg::cmd_text(atm_pkg::cmd_t'(k)),
                                 atm_pkg::cmd_len(atm_pkg::cmd_t'(k)), rd_pos)) begin
        match_next[k] = 1'b0;
      end
    end
    if (rd_pos >= 5'd4 && rd_pos <= 5'd20) begin
      if (rdata < atm_pkg::CHAR_ZERO || rdata > atm_pkg::CHAR_NINE) begin
        dig_ok_next = 1'b0;
      end
      if (rd_pos <= 5'd15) begin
        oct_next = (rd_pos inside {5'd4, 5'd7, 5'd10, 5'd13}) ? 10'(digit)
                   : 10'(oct * 10'd10) + 10'(digit);
        if (rd_pos inside {5'd6, 5'd9, 5'd12, 5'd15}) begin
          if (oct_next > 10'd255) begin
            dig_ok_next = 1'b0;
          end
          ip_next = {ip[23:0], oct_next[7:0]};
        end
      end else begin
        prt_next = (rd_pos == 5'd16) ? 17'(digit) : 17'(prt * 17'd10) + 17'(digit);
        if (rd_pos == 5'd20 && prt_next > 17'd65535) begin
          dig_ok_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (tidx == tcount - 5'd1) begin
      tchar = atm_pkg::CHAR_LF;
    end else if (tidx == tcount - 5'd2) begin
      tchar = atm_pkg::CHAR_CR;
    end else if (verbose) begin
      tchar = atm_pkg::byte_at(atm_pkg::msg_text(msg), mlen, tidx);
    end else begin
      tchar = atm_pkg::byte_at(atm_pkg::msg_text(msg), mlen, 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      verbose <= 1'b0;
      ovalid  <= 1'b0;
      rd_v    <= 1'b0;
    end else begin
      if (pop) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_v <= 1'b0;
          if (!q_empty) begin
            ch        <= q_head.channel;
            llen      <= q_head.length;
            msg       <= q_head.msg;
            post_kind <= atm_pkg::KIND_TEXT;
            tidx      <= 5'd0;
            issue_pos <= 5'd0;
            walk_n    <= (int'(q_head.length) < atm_pkg::WALK_MAX) ? 5'(q_head.length)
                         : 5'(atm_pkg::WALK_MAX);
            match     <= '1;
            dig_ok    <= 1'b1;
            state     <= q_head.run ? S_WALK : S_TEXT;
          end
        end
        S_WALK: begin
          rd_v   <= issue_pos < walk_n;
          rd_pos <= issue_pos;
          if (issue_pos < walk_n) begin
            issue_pos <= issue_pos + 5'd1;
          end
          if (rd_v) begin
            match  <= match_next;
            dig_ok <= dig_ok_next;
            oct    <= oct_next;
            prt    <= prt_next;
            ip     <= ip_next;
            if (rd_pos == walk_n - 5'd1) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          rd_v  <= 1'b0;
          state <= S_TEXT;
          if (llen == 7'd3 && match[atm_pkg::CMD_AT]) begin
            msg <= atm_pkg::MSG_AVAILABLE;
          end else if (llen >= 7'd4 && match[atm_pkg::CMD_ATDP]) begin
            if (llen == 7'(atm_pkg::WALK_MAX) && dig_ok) begin
              post_kind <= atm_pkg::KIND_CONNECT;
              state     <= S_POST;
            end else begin
              msg <= atm_pkg::MSG_NO_CONN;
            end
          end else if (llen == 7'd5 && match[atm_pkg::CMD_ATH0]) begin
            msg    <= atm_pkg::MSG_HUNG_UP;
            state  <= S_PRE;
          end else if (llen == 7'd5 && match[atm_pkg::CMD_ATV0]) begin
            msg     <= atm_pkg::MSG_VERBOSE;
            verbose <= 1'b0;
          end else if (llen == 7'd5 && match[atm_pkg::CMD_ATV1]) begin
            msg     <= atm_pkg::MSG_NUMERIC;
            verbose <= 1'b1;
          end else if (llen == 7'd11 && match[atm_pkg::CMD_RESTART]) begin
            msg       <= atm_pkg::MSG_RESTART;
            post_kind <= atm_pkg::KIND_RESTART;
          end else begin
            msg <= atm_pkg::MSG_UNKNOWN;
          end
        end
        S_PRE: begin
          if (slot_free) begin
            ovalid      <= 1'b1;
            kind        <= atm_pkg::KIND_DISCONNECT;
            out_channel <= ch;
            tx_byte     <= 8'd0;
            ip_address  <= 32'd0;
            port        <= 16'd0;
            last        <= 1'b0;
            state       <= S_TEXT;
          end
        end
        S_TEXT: begin
          if (slot_free) begin
            ovalid      <= 1'b1;
            kind        <= atm_pkg::KIND_TEXT;
            out_channel <= ch;
            tx_byte     <= tchar;
            ip_address  <= 32'd0;
            port        <= 16'd0;
            last        <= (tidx == tcount - 5'd1) && post_kind == atm_pkg::KIND_TEXT;
            tidx        <= tidx + 5'd1;
            if (tidx == tcount - 5'd1) begin
              state <= (post_kind == atm_pkg::KIND_TEXT) ? S_IDLE : S_POST;
            end
          end
        end
        S_POST: begin
          if (slot_free) begin
            ovalid      <= 1'b1;
            kind        <= post_kind;
            out_channel <= ch;
            tx_byte     <= 8'd0;
            ip_address  <= (post_kind == atm_pkg::KIND_CONNECT) ? ip : 32'd0;
            port        <= (post_kind == atm_pkg::KIND_CONNECT) ? prt[15:0] : 16'd0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/at_command_modem_frontend.sv @@
// a completed line is queued as a job; the back end walks its stored bytes (up to 22),
// decides the command and then sends the answer
// throughput: other items one per cycle while the two-entry job queue has room and no line
// is pending; a line end holds full high until its walk is decided;
// text results then follow one per cycle while pop is held
// reset: synchronous, clears modes, line and escape state, queue and result register; store kept
module at_command_modem_frontend #(
  parameter int CHANNELS   = 4,
  parameter int LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [1:0]  channel,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [1:0]  out_channel,
  output logic [7:0]  tx_byte,
  output logic [31:0] ip_address,
  output logic [15:0] port,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                job_push;
  atm_pkg::job_t       job;
  logic                job_full;
  atm_pkg::store_wr_t  store_wr;
  logic                run_done;
  logic                q_pop;
  logic                q_empty;
  atm_pkg::job_t       q_head;

  atm_front #(.CHANNELS(CHANNELS), .LINE_BYTES(LINE_BYTES)) u_front (
    .clk, .rst, .push, .full, .operation, .channel, .rx_byte,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .job_push, .job, .job_full, .store_wr, .run_done
  );

  atm_queue u_queue (
    .clk, .rst,
    .push(job_push), .push_job(job), .full(job_full),
    .pop(q_pop), .head(q_head), .empty(q_empty)
  );

  atm_back #(.CHANNELS(CHANNELS), .LINE_BYTES(LINE_BYTES)) u_back (
    .clk, .rst, .store_wr, .q_empty, .q_head, .q_pop, .run_done,
    .empty, .pop, .kind, .out_channel, .tx_byte, .ip_address, .port, .last
  );

endmodule

@@ rtl/atm_checker.sv @@
// atm_checker: port-level checks of the modem front end over time, bound to the top level
// depends on atm_pkg and at_command_modem_frontend ports
module atm_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic [7:0]  tx_byte,
  input logic [31:0] ip_address,
  input logic [15:0] port,
  input logic        last
);

  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(kind) && $stable(tx_byte) && $stable(last))
    else $error("result changed before transfer");

  a_req_no_text: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != atm_pkg::KIND_TEXT |-> tx_byte == 8'd0)
    else $error("request carries text");

  a_addr_only_connect: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != atm_pkg::KIND_CONNECT |-> ip_address == 32'd0 && port == 16'd0)
    else $error("address on non-connect result");

  a_req_last: assert property (@(posedge clk) disable iff (rst)
    !empty && (kind == atm_pkg::KIND_CONNECT || kind == atm_pkg::KIND_RESTART) |-> last)
    else $error("connect or restart not final");

endmodule

bind at_command_modem_frontend atm_checker u_atm_checker (.*);

@@ dv/tb.sv @@
// tb: self-checking testbench for the AT command modem front end
// predicts answers, requests and escapes per channel in a small scoreboard class
// depends on atm_pkg and at_command_modem_frontend
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 4;
  localparam int LB = 32;
  localparam int DRAIN = 40;
  localparam int WATCHDOG = 5000;
  localparam logic CFG_MASK = 1'b0;
  localparam logic CFG_GUARD = 1'b1;

  typedef struct {
    logic [1:0] kind;
    logic [1:0] chan;
    logic [7:0] tx;
    logic [31:0] ip;
    logic [15:0] port;
    logic last;
  } modem_result_t;

  class modem_scoreboard;
    logic [3:0] mask = 4'd0;
    logic [7:0] guard = 8'd10;
    logic data_mode[NCH];
    logic collecting[NCH];
    logic [7:0] store[NCH][LB];
    int unsigned len[NCH];
    atm_pkg::phase_t phase[NCH];
    logic [7:0] silence[NCH];
    logic verbose = 1'b0;
    modem_result_t answers[$];
    modem_result_t fresh[$];
    logic [1:0] cur;
    int errors = 0;
    int results = 0;

    function new();
      for (int c = 0; c < NCH; c++) begin
        data_mode[c] = 0;
        collecting[c] = 0;
        len[c] = 0;
        phase[c] = atm_pkg::PH_BEGIN;
        silence[c] = 0;
      end
    endfunction

    function void emit(atm_pkg::kind_e k, logic [7:0] tx, logic [31:0] ip, logic [15:0] prt);
      modem_result_t r;
      r.kind = k;
      r.chan = cur;
      r.tx = tx;
      r.ip = ip;
      r.port = prt;
      r.last = 0;
      if (fresh.size() < 26) fresh.push_back(r);
    endfunction

    function void reply(int code, string txt);
      if (verbose) begin
        for (int i = 0; i < txt.len(); i++) emit(atm_pkg::KIND_TEXT, txt[i], 32'd0, 16'd0);
      end else begin
        emit(atm_pkg::KIND_TEXT, 8'(int'(atm_pkg::CHAR_ZERO) + code), 32'd0, 16'd0);
      end
      emit(atm_pkg::KIND_TEXT, atm_pkg::CHAR_CR, 32'd0, 16'd0);
      emit(atm_pkg::KIND_TEXT, atm_pkg::CHAR_LF, 32'd0, 16'd0);
    endfunction

    function logic [7:0] up(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    function bit eol(logic [7:0] c);
      return c == atm_pkg::CHAR_CR || c == atm_pkg::CHAR_LF;
    endfunction

    function bit line_is(int ch, string cmd, bit exact);
      int i;
      for (i = 0; i < cmd.len(); i++) begin
        if (i >= len[ch]) return 0;
        if (up(store[ch][i % LB]) != up(cmd[i])) return 0;
      end
      if (!exact) return 1;
      return i < len[ch] && eol(store[ch][i % LB]);
    endfunction

    function bit digits(int ch, ref int pos, input int n, output int unsigned val);
      logic [7:0] c;
      val = 0;
      for (int k = 0; k < n; k++) begin
        if (pos >= len[ch] || pos >= LB) return 0;
        c = store[ch][pos % LB];
        pos++;
        if (c < atm_pkg::CHAR_ZERO || c > atm_pkg::CHAR_NINE) return 0;
        val = val * 10 + (c - atm_pkg::CHAR_ZERO);
      end
      return 1;
    endfunction

    function bit dial(int ch);
      int pos;
      int unsigned v, prt;
      logic [31:0] ip;
      pos = 4;
      ip = 0;
      for (int k = 0; k < 4; k++) begin
        if (!digits(ch, pos, 3, v) || v > 255) return 0;
        ip = {ip[23:0], v[7:0]};
      end
      if (!digits(ch, pos, 5, prt) || prt > 65535) return 0;
      if (pos >= len[ch] || pos >= LB || !eol(store[ch][pos % LB])) return 0;
      emit(atm_pkg::KIND_CONNECT, 8'd0, ip, prt[15:0]);
      return 1;
    endfunction

    function void run_line(int ch);
      if (line_is(ch, "at", 1)) reply(0, "0 OK, modem available");
      else if (line_is(ch, "atdp", 0)) begin
        if (!dial(ch)) reply(4, "4 ERROR, no connection");
      end else if (line_is(ch, "ath0", 1)) begin
        emit(atm_pkg::KIND_DISCONNECT, 8'd0, 32'd0, 16'd0);
        reply(0, "0 OK, disconnected");
      end else if (line_is(ch, "atv0", 1)) begin
        verbose = 0;
        reply(0, "0 OK, verbose answers");
      end else if (line_is(ch, "atv1", 1)) begin
        verbose = 1;
        reply(0, "0 OK, numeric answers");
      end else if (line_is(ch, "at-restart", 1)) begin
        reply(0, "0 OK, going to restart");
        emit(atm_pkg::KIND_RESTART, 8'd0, 32'd0, 16'd0);
      end else reply(4, "4 ERROR, unknown command");
    endfunction

    function void note(logic [1:0] op, logic [1:0] ch, logic [7:0] b);
      fresh.delete();
      cur = ch;
      if (mask[ch]) begin
        if (op == atm_pkg::OP_BYTE && data_mode[ch]) begin
          silence[ch] = 0;
          if (phase[ch] == atm_pkg::PH_PAUSE_BEFORE && b == atm_pkg::CHAR_PLUS)
            phase[ch] = atm_pkg::PH_PLUS1;
          else if (phase[ch] == atm_pkg::PH_PLUS1 && b == atm_pkg::CHAR_PLUS)
            phase[ch] = atm_pkg::PH_PLUS2;
          else if (phase[ch] == atm_pkg::PH_PLUS2 && b == atm_pkg::CHAR_PLUS)
            phase[ch] = atm_pkg::PH_PLUS3;
          else phase[ch] = atm_pkg::PH_DATA;
        end else if (op == atm_pkg::OP_BYTE) begin
          if (!collecting[ch]) begin
            collecting[ch] = 1;
            len[ch] = 0;
          end
          if (len[ch] >= LB) len[ch] = 0;
          store[ch][len[ch]] = b;
          len[ch]++;
          if (eol(b)) begin
            run_line(ch);
            collecting[ch] = 0;
          end
        end else if (op == atm_pkg::OP_TICK) begin
          if (silence[ch] >= guard) begin
            if (phase[ch] == atm_pkg::PH_DATA) phase[ch] = atm_pkg::PH_PAUSE_BEFORE;
            else if (phase[ch] == atm_pkg::PH_PLUS3) phase[ch] = atm_pkg::PH_PAUSE_AFTER;
          end else silence[ch]++;
          if (data_mode[ch] && phase[ch] == atm_pkg::PH_PAUSE_AFTER) begin
            data_mode[ch] = 0;
            reply(0, "0 OK, command mode");
            phase[ch] = atm_pkg::PH_BEGIN;
          end
        end else if (op == atm_pkg::OP_LINK && !data_mode[ch]) begin
          data_mode[ch] = 1;
          reply(1, "1 CONNECT");
        end
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1;
      foreach (fresh[i]) answers.push_back(fresh[i]);
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check(modem_result_t act);
      modem_result_t e;
      results++;
      if (answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d tx %0h",
                 $time, act.kind, act.tx);
        return;
      end
      e = answers.pop_front();
      field("kind", e.kind, act.kind);
      field("out_channel", e.chan, act.chan);
      field("tx_byte", e.tx, act.tx);
      field("ip_address", e.ip, act.ip);
      field("port", e.port, act.port);
      field("last", e.last, act.last);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [1:0] operation = 0;
  logic [1:0] channel = 0;
  logic [7:0] rx_byte = 0;
  logic empty;
  logic pop = 0;
  logic [1:0] kind;
  logic [1:0] out_channel;
  logic [7:0] tx_byte;
  logic [31:0] ip_address;
  logic [15:0] port;
  logic last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [7:0] cfg_data = 0;

  modem_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int items = 0;
  int quiet = 0;

  at_command_modem_frontend dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    modem_result_t r;
    if (!rst && pop && !empty) begin
      r.kind = kind;
      r.chan = out_channel;
      r.tx = tx_byte;
      r.ip = ip_address;
      r.port = port;
      r.last = last;
      sb.check(r);
    end
    if ((pop && !empty) || (push && !full) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("FAILED: results differ");
      $finish;
    end
    pop <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_item(logic [1:0] op, logic [1:0] ch, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    operation <= op;
    channel <= ch;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note(op, ch, b);
    items++;
  endtask

  task automatic send_text(logic [1:0] ch, string s);
    for (int i = 0; i < s.len(); i++) send_item(atm_pkg::OP_BYTE, ch, s[i]);
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (sb.answers.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
    if (idx == CFG_MASK) sb.mask = v[3:0];
    else sb.guard = v;
  endtask

  function automatic string mixcase(string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++)
      if (t[i] >= "a" && t[i] <= "z" && $urandom_range(1)) t[i] = t[i] - 8'h20;
    return t;
  endfunction

  function automatic string dial_text(bit good);
    string s;
    s = "atdp";
    for (int k = 0; k < 4; k++)
      s = {s, $sformatf("%03d", (good || $urandom_range(3)) ? $urandom_range(255)
                                                            : $urandom_range(999, 256))};
    s = {s, $sformatf("%05d", good ? $urandom_range(65535) : $urandom_range(99999))};
    if (!good && $urandom_range(1)) s = s.substr(0, $urandom_range(4, s.len() - 1));
    return s;
  endfunction

  task automatic random_burst(logic [1:0] ch);
    string cmds[8];
    string eolx;
    int r;
    cmds = '{"at", "ath0", "atv0", "atv1", "at-restart", "atx", "", "at+"};
    r = $urandom_range(99);
    eolx = $urandom_range(3) == 0 ? "\r\n" : ($urandom_range(1) ? "\r" : "\n");
    if (r < 30) send_text(ch, {mixcase(cmds[$urandom_range(7)]), eolx});
    else if (r < 48) send_text(ch, {mixcase(dial_text($urandom_range(2) != 0)), eolx});
    else if (r < 58) send_item(atm_pkg::OP_LINK, ch, 8'($urandom));
    else if (r < 72 && sb.guard <= 12) begin
      repeat (sb.guard + 1) send_item(atm_pkg::OP_TICK, ch, 8'($urandom));
      send_text(ch, "+++");
      repeat (sb.guard + 1) send_item(atm_pkg::OP_TICK, ch, 8'($urandom));
    end else if (r < 88) send_item(2'($urandom_range(1)), ch, 8'($urandom));
    else send_item(2'($urandom_range(3)), ch, 8'($urandom));
  endtask

  initial begin
    int idle_q[4];
    int stall_q[4];
    int mask_q[5];
    int guard_q[5];
    string longline;
    idle_q = '{0, 58, 0, 18};
    stall_q = '{0, 0, 58, 18};
    mask_q = '{15, 5, 15, 10, 0};
    guard_q = '{2, 0, 255, 1, 10};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every command, dial extremes, escape, lone end of line, wrap
    write_reg(CFG_MASK, 8'hff);
    write_reg(CFG_GUARD, 8'd1);
    send_text(2'd0, "AT\r");
    send_text(2'd0, "\r\n");
    send_text(2'd1, "aTv1\n");
    send_text(2'd1, "At-ReStArT\r");
    send_text(2'd2, "ATH0\r");
    send_text(2'd2, {"ATDP", "000000000000", "00000", "\r"});
    send_text(2'd3, "atdp25525525525565535\n");
    send_text(2'd3, "atdp12345\r");
    send_text(2'd0, "ATV0\r");
    send_item(2'd3, 2'd0, 8'hff);
    send_item(atm_pkg::OP_LINK, 2'd1, 8'h00);
    send_item(atm_pkg::OP_LINK, 2'd1, 8'h00);
    repeat (2) send_item(atm_pkg::OP_TICK, 2'd1, 8'h00);
    send_text(2'd1, "+++");
    repeat (2) send_item(atm_pkg::OP_TICK, 2'd1, 8'h00);
    longline = "";
    repeat (34) longline = {longline, "x"};
    send_text(2'd2, {longline, "\r"});
    drain();

    for (int p = 0; p < 5; p++) begin
      int g;
      int n;
      write_reg(CFG_MASK, 8'(mask_q[p]));
      write_reg(CFG_GUARD, 8'(guard_q[p]));
      g = p % 4;
      send_idle = idle_q[g];
      recv_stall = stall_q[g];
      n = items + (p == 4 ? 3 : 6);
      while (items < n) random_burst(2'($urandom_range(3)));
      send_idle = 0;
      recv_stall = 0;
      drain();
    end

    $display("run covered %0d input items and %0d results over 5 register settings",
             items, sb.results);
    $display("idling phases: none, sender only, receiver only, both sides");
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.answers.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
